@@ sv/fbl_pkg.sv @@
package fbl_pkg;

  localparam int FLOW_W = 16;
  localparam int END_W = FLOW_W + 1;
  localparam int SUM_W = FLOW_W + 2;
  localparam int SEG_SLOTS = 4;
  localparam int SEG_W = 2;
  localparam int CNT_W = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = FLOW_W / DIV_STAGES;
  localparam logic [FLOW_W-1:0] RESET_SIZE0 = FLOW_W'(20);
  localparam logic [FLOW_W-1:0] INDEX_MAX = '1;

  typedef enum logic [2:0] {
    REG_SEG_COUNT,
    REG_START_SEG1,
    REG_START_SEG2,
    REG_START_SEG3,
    REG_SIZE_SEG0,
    REG_SIZE_SEG1,
    REG_SIZE_SEG2,
    REG_SIZE_SEG3
  } reg_index_t;

  typedef struct packed {
    logic [CNT_W-1:0] segment_count;
    logic [SEG_SLOTS-1:0][FLOW_W-1:0] start;
    logic [SEG_SLOTS-1:0][FLOW_W-1:0] size;
  } cfg_t;

  // one divider lane: partial remainder, unshifted dividend bits, quotient, divisor
  typedef struct packed {
    logic [FLOW_W-1:0] rem;
    logic [FLOW_W-1:0] dvd;
    logic [FLOW_W-1:0] quo;
    logic [FLOW_W-1:0] dsr;
  } lane_t;

  // lane 0 divides the flow offset, lanes 1..3 divide the spans of earlier segments
  typedef struct packed {
    lane_t [SEG_SLOTS-1:0] lane;
    logic [FLOW_W-1:0] flow;
    logic [FLOW_W-1:0] seg_start;
    logic [FLOW_W-1:0] seg_size;
    logic [SEG_SLOTS-1:1] count_en;
    logic [SEG_SLOTS-1:1] check_en;
    logic in_first;
    logic [FLOW_W-1:0] largest;
    logic invalid;
  } div_pipe_t;

  typedef struct packed {
    logic [FLOW_W-1:0] block_index;
    logic [FLOW_W-1:0] block_begin;
    logic [END_W-1:0] block_end;
    logic [FLOW_W-1:0] block_length;
    logic in_first_block;
    logic [FLOW_W-1:0] largest_block;
    logic table_invalid;
  } res_t;

  function automatic lane_t div_step(lane_t l);
    logic [FLOW_W:0] r;
    lane_t o;
    o = l;
    r = {l.rem, l.dvd[FLOW_W-1]};
    o.dvd = {l.dvd[FLOW_W-2:0], 1'b0};
    if (r >= {1'b0, l.dsr}) begin
      o.rem = FLOW_W'(r - {1'b0, l.dsr});
      o.quo = {l.quo[FLOW_W-2:0], 1'b1};
    end else begin
      o.rem = r[FLOW_W-1:0];
      o.quo = {l.quo[FLOW_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ sv/fbl_cfg.sv @@
module fbl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbl_pkg::ADDR_W-1:0]  paddr,
  input  logic [fbl_pkg::DATA_W-1:0]  pwdata,
  output logic [fbl_pkg::DATA_W-1:0]  prdata,
  output fbl_pkg::cfg_t               cfg
);

  logic [fbl_pkg::CNT_W-1:0] segment_count;
  logic [fbl_pkg::SEG_SLOTS-1:1][fbl_pkg::FLOW_W-1:0] start_seg;
  logic [fbl_pkg::SEG_SLOTS-1:0][fbl_pkg::FLOW_W-1:0] size_seg;
  fbl_pkg::reg_index_t reg_sel;
  logic wr_en;

  assign reg_sel = fbl_pkg::reg_index_t'(paddr[fbl_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= fbl_pkg::CNT_W'(1);
      start_seg <= '0;
      size_seg <= {{((fbl_pkg::SEG_SLOTS-1)*fbl_pkg::FLOW_W){1'b0}}, fbl_pkg::RESET_SIZE0};
    end else if (wr_en) begin
      case (reg_sel)
        fbl_pkg::REG_SEG_COUNT:  segment_count <= pwdata[fbl_pkg::CNT_W-1:0];
        fbl_pkg::REG_START_SEG1: start_seg[1] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_START_SEG2: start_seg[2] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_START_SEG3: start_seg[3] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_SIZE_SEG0:  size_seg[0] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_SIZE_SEG1:  size_seg[1] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_SIZE_SEG2:  size_seg[2] <= pwdata[fbl_pkg::FLOW_W-1:0];
        fbl_pkg::REG_SIZE_SEG3:  size_seg[3] <= pwdata[fbl_pkg::FLOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fbl_pkg::REG_SEG_COUNT:  prdata = fbl_pkg::DATA_W'(segment_count);
      fbl_pkg::REG_START_SEG1: prdata = fbl_pkg::DATA_W'(start_seg[1]);
      fbl_pkg::REG_START_SEG2: prdata = fbl_pkg::DATA_W'(start_seg[2]);
      fbl_pkg::REG_START_SEG3: prdata = fbl_pkg::DATA_W'(start_seg[3]);
      fbl_pkg::REG_SIZE_SEG0:  prdata = fbl_pkg::DATA_W'(size_seg[0]);
      fbl_pkg::REG_SIZE_SEG1:  prdata = fbl_pkg::DATA_W'(size_seg[1]);
      fbl_pkg::REG_SIZE_SEG2:  prdata = fbl_pkg::DATA_W'(size_seg[2]);
      fbl_pkg::REG_SIZE_SEG3:  prdata = fbl_pkg::DATA_W'(size_seg[3]);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    cfg.segment_count = segment_count;
    cfg.start = {start_seg, {fbl_pkg::FLOW_W{1'b0}}};
    cfg.size = size_seg;
  end

endmodule

@@ sv/fbl_select.sv @@
module fbl_select (
  input  logic                       clk,
  input  logic                       rst,
  input  fbl_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  input  logic [fbl_pkg::FLOW_W-1:0] flow,
  output logic                       in_ready,
  output logic                       out_valid,
  output fbl_pkg::div_pipe_t         out_data,
  input  logic                       out_ready
);

  fbl_pkg::div_pipe_t out_data_next;
  logic [fbl_pkg::CNT_W-1:0] used;
  logic [fbl_pkg::SEG_W-1:0] seg;
  logic [fbl_pkg::SEG_SLOTS-1:1] span_pos;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    used = cfg.segment_count;
    if (used == '0) used = fbl_pkg::CNT_W'(1);
    if (used > fbl_pkg::CNT_W'(fbl_pkg::SEG_SLOTS)) used = fbl_pkg::CNT_W'(fbl_pkg::SEG_SLOTS);

    // highest segment in use whose start is at or below the flow
    seg = '0;
    for (int i = 1; i < fbl_pkg::SEG_SLOTS; i++) begin
      if ((fbl_pkg::CNT_W'(i) < used) && (cfg.start[i] <= flow)) seg = fbl_pkg::SEG_W'(i);
    end

    out_data_next = '0;
    out_data_next.flow = flow;
    out_data_next.seg_start = cfg.start[seg];
    out_data_next.seg_size = cfg.size[seg];
    out_data_next.in_first = flow < cfg.size[0];
    out_data_next.lane[0].dvd = flow - cfg.start[seg];
    out_data_next.lane[0].dsr = cfg.size[seg];

    out_data_next.largest = fbl_pkg::FLOW_W'(1);
    out_data_next.invalid = 1'b0;
    for (int i = 0; i < fbl_pkg::SEG_SLOTS; i++) begin
      if (fbl_pkg::CNT_W'(i) < used) begin
        if (cfg.size[i] == '0) out_data_next.invalid = 1'b1;
        if (cfg.size[i] > out_data_next.largest) out_data_next.largest = cfg.size[i];
      end
    end

    for (int i = 1; i < fbl_pkg::SEG_SLOTS; i++) begin
      span_pos[i] = cfg.start[i] > cfg.start[i-1];
      out_data_next.lane[i].dvd = cfg.start[i] - cfg.start[i-1];
      out_data_next.lane[i].dsr = cfg.size[i-1];
      out_data_next.count_en[i] = (fbl_pkg::SEG_W'(i) <= seg) && span_pos[i]
                                  && (cfg.size[i-1] != '0);
      out_data_next.check_en[i] = (fbl_pkg::CNT_W'(i) < used) && span_pos[i]
                                  && (cfg.size[i-1] != '0);
      if ((fbl_pkg::CNT_W'(i) < used) && !span_pos[i]) out_data_next.invalid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= out_data_next;
    end
  end

endmodule

@@ sv/fbl_div_stage.sv @@
module fbl_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  fbl_pkg::div_pipe_t in_data,
  output logic               in_ready,
  output logic               out_valid,
  output fbl_pkg::div_pipe_t out_data,
  input  logic               out_ready
);

  fbl_pkg::div_pipe_t out_data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    out_data_next = in_data;
    for (int l = 0; l < fbl_pkg::SEG_SLOTS; l++) begin
      for (int b = 0; b < fbl_pkg::BITS_PER_STAGE; b++) begin
        out_data_next.lane[l] = fbl_pkg::div_step(out_data_next.lane[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= out_data_next;
    end
  end

endmodule

@@ sv/fbl_finish.sv @@
module fbl_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  fbl_pkg::div_pipe_t in_data,
  output logic               in_ready,
  output logic               out_valid,
  output fbl_pkg::res_t      out_data,
  input  logic               out_ready
);

  fbl_pkg::res_t out_data_next;
  logic [fbl_pkg::SUM_W-1:0] total;
  logic [fbl_pkg::FLOW_W-1:0] rep;
  logic size_nz;
  logic rem_bad;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    size_nz = in_data.seg_size != '0;
    rep = size_nz ? in_data.lane[0].quo : '0;
    total = fbl_pkg::SUM_W'(rep);
    rem_bad = 1'b0;
    for (int i = 1; i < fbl_pkg::SEG_SLOTS; i++) begin
      if (in_data.count_en[i]) total = total + fbl_pkg::SUM_W'(in_data.lane[i].quo);
      if (in_data.check_en[i] && (in_data.lane[i].rem != '0)) rem_bad = 1'b1;
    end

    out_data_next.block_index = (total > fbl_pkg::SUM_W'(fbl_pkg::INDEX_MAX))
                                ? fbl_pkg::INDEX_MAX : total[fbl_pkg::FLOW_W-1:0];
    // begin is flow minus remainder; seg_start if size is 0
    out_data_next.block_begin = size_nz ? (in_data.flow - in_data.lane[0].rem)
                                        : in_data.seg_start;
    out_data_next.block_end = fbl_pkg::END_W'(out_data_next.block_begin)
                              + fbl_pkg::END_W'(in_data.seg_size);
    out_data_next.block_length = in_data.seg_size;
    out_data_next.in_first_block = in_data.in_first;
    out_data_next.largest_block = in_data.largest;
    out_data_next.table_invalid = in_data.invalid || rem_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= out_data_next;
    end
  end

endmodule

@@ sv/flow_block_locator.sv @@
// Locates a flow number in a table of up to four segments, each cut into blocks of its
// own size, and returns the global block index, the block bounds and size, a first-block
// flag, the largest block size in use and a table check. One flow is taken every clock
// cycle unless the full pipeline stalls, and passes through one segment-select stage,
// four divider stages that each resolve four quotient bits for the flow offset and the
// three segment spans, and one summing stage that doubles as the output register.
// Stalls on the result side fill bubbles first, so input is taken while a bubble is
// left. Nothing needs clearing after reset. The segment table is to be written by the
// user over the register port only while no flow is in flight, unchecked by the block.
module flow_block_locator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // flow
  output logic        m_tvalid,
  input  logic        m_tready,
  // block_index, block_begin, block_end, block_length, in_first_block,
  // largest_block, table_invalid, zero pad
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fbl_pkg::cfg_t cfg;
  fbl_pkg::div_pipe_t stage_data [fbl_pkg::DIV_STAGES+1];
  logic [fbl_pkg::DIV_STAGES:0] stage_valid;
  logic [fbl_pkg::DIV_STAGES:0] stage_ready;
  logic fin_ready;
  fbl_pkg::res_t res;

  assign pready = 1'b1;

  fbl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fbl_select u_select (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .flow      (s_tdata),
    .in_ready  (s_tready),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0]),
    .out_ready (stage_ready[0])
  );

  for (genvar g = 0; g < fbl_pkg::DIV_STAGES; g++) begin : g_div
    fbl_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_data   (stage_data[g]),
      .in_ready  (stage_ready[g]),
      .out_valid (stage_valid[g+1]),
      .out_data  (stage_data[g+1]),
      .out_ready (g == fbl_pkg::DIV_STAGES - 1 ? fin_ready : stage_ready[g+1])
    );
  end

  fbl_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[fbl_pkg::DIV_STAGES]),
    .in_data   (stage_data[fbl_pkg::DIV_STAGES]),
    .in_ready  (fin_ready),
    .out_valid (m_tvalid),
    .out_data  (res),
    .out_ready (m_tready)
  );

  assign stage_ready[fbl_pkg::DIV_STAGES] = fin_ready;

  assign m_tdata = {5'b0, res.table_invalid, res.largest_block, res.in_first_block,
                    res.block_length, res.block_end, res.block_begin, res.block_index};

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stage_valid[0])
    else $error("accepted transaction did not reach the select stage");

  a_end_matches : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.block_end == (17'(res.block_begin) + 17'(res.block_length)))
    else $error("block end is not begin plus length");

  a_valid_size : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.table_invalid |-> res.block_length != '0)
    else $error("zero block length on a valid table");

  a_largest : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.largest_block >= res.block_length && res.largest_block != '0)
    else $error("largest block below the block in use");

endmodule
